>>> design/fscrs_pkg.sv
// shared types and constants for the float sign-change root sweep
package fscrs_pkg;

    // binary32 encodings
    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [31:0] QNAN      = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;

    // configuration register reset values (1.1 and 2.2)
    localparam logic [31:0] RESET_OFFSET_A = 32'h3F8C_CCCD;
    localparam logic [31:0] RESET_OFFSET_B = 32'h400C_CCCD;

    // configuration register indexes
    typedef logic [7:0] cfg_idx_t;
    localparam cfg_idx_t REG_OFFSET_A = 8'd0;
    localparam cfg_idx_t REG_OFFSET_B = 8'd1;

    // special-value classification that rides along the arithmetic pipes
    typedef struct packed {
        logic nan;
        logic inf;
        logic sgn;
    } spec_t;

endpackage

>>> design/fscrs_add.sv
// four-stage binary32 adder, round to nearest even, subnormals kept
module fscrs_add (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [31:0] sum
);

    // stage 1: classify, order by magnitude, align the smaller operand
    logic               nan_a, nan_b, inf_a, inf_b, a_big;
    logic [31:0]        big, sml;
    logic [7:0]         e_big, e_sml, e_diff;
    logic [23:0]        sig_big, sig_sml;
    logic [26:0]        sml_ext, sml_sh;
    logic               sml_st;
    fscrs_pkg::spec_t   spec1;

    always_comb begin
        nan_a = (op_a[30:23] == fscrs_pkg::EXP_MAX) && (op_a[22:0] != 23'd0);
        nan_b = (op_b[30:23] == fscrs_pkg::EXP_MAX) && (op_b[22:0] != 23'd0);
        inf_a = (op_a[30:23] == fscrs_pkg::EXP_MAX) && (op_a[22:0] == 23'd0);
        inf_b = (op_b[30:23] == fscrs_pkg::EXP_MAX) && (op_b[22:0] == 23'd0);
        spec1.nan = nan_a || nan_b || (inf_a && inf_b && (op_a[31] != op_b[31]));
        spec1.inf = !spec1.nan && (inf_a || inf_b);
        spec1.sgn = inf_a ? op_a[31] : op_b[31];
        a_big   = (op_a[30:0] >= op_b[30:0]);
        big     = a_big ? op_a : op_b;
        sml     = a_big ? op_b : op_a;
        e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_sml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        sig_big = {big[30:23] != 8'd0, big[22:0]};
        sig_sml = {sml[30:23] != 8'd0, sml[22:0]};
        e_diff  = e_big - e_sml;
        sml_ext = {sig_sml, 3'b000};
        if (e_diff >= 8'd27) begin
            sml_sh = '0;
            sml_st = |sml_ext;
        end else begin
            sml_sh = sml_ext >> e_diff;
            sml_st = ((sml_sh << e_diff) != sml_ext);
        end
    end

    logic               s1_sign_reg, s1_sub_reg, s1_zsign_reg;
    logic [7:0]         s1_exp_reg;
    logic [26:0]        s1_big_reg, s1_sml_reg;
    fscrs_pkg::spec_t   s1_spec_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sign_reg  <= big[31];
            s1_sub_reg   <= big[31] ^ sml[31];
            s1_zsign_reg <= big[31] & sml[31];
            s1_exp_reg   <= e_big;
            s1_big_reg   <= {sig_big, 3'b000};
            s1_sml_reg   <= {sml_sh[26:1], sml_sh[0] | sml_st};
            s1_spec_reg  <= spec1;
        end
    end

    // stage 2: magnitude add or subtract
    logic               s2_sign_reg, s2_zsign_reg;
    logic [7:0]         s2_exp_reg;
    logic [27:0]        s2_sum_reg;
    fscrs_pkg::spec_t   s2_spec_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_sign_reg  <= s1_sign_reg;
            s2_zsign_reg <= s1_zsign_reg;
            s2_exp_reg   <= s1_exp_reg;
            s2_spec_reg  <= s1_spec_reg;
            if (s1_sub_reg) begin
                s2_sum_reg <= {1'b0, s1_big_reg} - {1'b0, s1_sml_reg};
            end else begin
                s2_sum_reg <= {1'b0, s1_big_reg} + {1'b0, s1_sml_reg};
            end
        end
    end

    // stage 3: leading zero count and normalize, stopping at the subnormal floor
    logic [4:0]         lz, nsh;
    logic [7:0]         lim;
    logic [26:0]        norm;
    logic [9:0]         nexp;

    always_comb begin
        lz = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (s2_sum_reg[i]) lz = 5'(26 - i);
        end
        lim = s2_exp_reg - 8'd1;
        nsh = '0;
        if (s2_sum_reg[27]) begin
            norm = {s2_sum_reg[27:2], s2_sum_reg[1] | s2_sum_reg[0]};
            nexp = {2'b00, s2_exp_reg} + 10'd1;
        end else begin
            nsh  = ({3'b000, lz} <= lim) ? lz : lim[4:0];
            norm = s2_sum_reg[26:0] << nsh;
            nexp = {2'b00, s2_exp_reg} - {5'b00000, nsh};
        end
    end

    logic               s3_sign_reg, s3_zsign_reg, s3_zero_reg;
    logic [9:0]         s3_exp_reg;
    logic [26:0]        s3_norm_reg;
    fscrs_pkg::spec_t   s3_spec_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_sign_reg  <= s2_sign_reg;
            s3_zsign_reg <= s2_zsign_reg;
            s3_zero_reg  <= (s2_sum_reg == 28'd0);
            s3_exp_reg   <= nexp;
            s3_norm_reg  <= norm;
            s3_spec_reg  <= s2_spec_reg;
        end
    end

    // stage 4: round to nearest even and pack
    logic               rnd_up;
    logic [24:0]        mant;
    logic [23:0]        mfin;
    logic [9:0]         efin;
    logic [7:0]         efld;
    logic [31:0]        sum_next;

    always_comb begin
        rnd_up = s3_norm_reg[2] & (s3_norm_reg[1] | s3_norm_reg[0] | s3_norm_reg[3]);
        mant   = {1'b0, s3_norm_reg[26:3]} + {24'd0, rnd_up};
        if (mant[24]) begin
            mfin = mant[24:1];
            efin = s3_exp_reg + 10'd1;
        end else begin
            mfin = mant[23:0];
            efin = s3_exp_reg;
        end
        efld = mfin[23] ? efin[7:0] : 8'd0;
        if (s3_spec_reg.nan) begin
            sum_next = fscrs_pkg::QNAN;
        end else if (s3_spec_reg.inf) begin
            sum_next = {s3_spec_reg.sgn, fscrs_pkg::EXP_MAX, 23'd0};
        end else if (s3_zero_reg) begin
            sum_next = {s3_zsign_reg, 31'd0};
        end else if (efin >= 10'd255) begin
            sum_next = {s3_sign_reg, fscrs_pkg::EXP_MAX, 23'd0};
        end else begin
            sum_next = {s3_sign_reg, efld, mfin[22:0]};
        end
    end

    logic [31:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

>>> design/fscrs_mul.sv
// four-stage binary32 multiplier, round to nearest even, subnormals kept
module fscrs_mul (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [31:0] prod
);

    // stage 1: classify and multiply significands
    logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [7:0]         e_a, e_b;
    logic [23:0]        sig_a, sig_b;
    logic [8:0]         e_add;
    logic signed [10:0] e_raw;
    fscrs_pkg::spec_t   spec1;
    logic               zero1;

    always_comb begin
        nan_a  = (op_a[30:23] == fscrs_pkg::EXP_MAX) && (op_a[22:0] != 23'd0);
        nan_b  = (op_b[30:23] == fscrs_pkg::EXP_MAX) && (op_b[22:0] != 23'd0);
        inf_a  = (op_a[30:23] == fscrs_pkg::EXP_MAX) && (op_a[22:0] == 23'd0);
        inf_b  = (op_b[30:23] == fscrs_pkg::EXP_MAX) && (op_b[22:0] == 23'd0);
        zero_a = (op_a[30:0] == 31'd0);
        zero_b = (op_b[30:0] == 31'd0);
        spec1.nan = nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a);
        spec1.inf = !spec1.nan && (inf_a || inf_b);
        spec1.sgn = op_a[31] ^ op_b[31];
        zero1     = zero_a || zero_b;
        e_a   = (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23];
        e_b   = (op_b[30:23] == 8'd0) ? 8'd1 : op_b[30:23];
        sig_a = {op_a[30:23] != 8'd0, op_a[22:0]};
        sig_b = {op_b[30:23] != 8'd0, op_b[22:0]};
        e_add = {1'b0, e_a} + {1'b0, e_b};
        e_raw = $signed({2'b00, e_add}) - 11'sd126;
    end

    logic [47:0]        s1_p_reg;
    logic signed [10:0] s1_e_reg;
    logic               s1_zero_reg;
    fscrs_pkg::spec_t   s1_spec_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_p_reg    <= sig_a * sig_b;
            s1_e_reg    <= e_raw;
            s1_zero_reg <= zero1;
            s1_spec_reg <= spec1;
        end
    end

    // stage 2: leading zero count and shift plan
    logic [5:0]         lz;
    logic signed [11:0] e_ext, e_lz, r_amt;
    logic               left;
    logic [5:0]         sh;
    logic [9:0]         nexp;

    always_comb begin
        lz = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (s1_p_reg[i]) lz = 6'(47 - i);
        end
        e_ext = {s1_e_reg[10], s1_e_reg};
        e_lz  = e_ext - $signed({6'b000000, lz});
        r_amt = 12'sd1 - e_ext;
        if (e_lz >= 12'sd1) begin
            left = 1'b1;
            sh   = lz;
            nexp = e_lz[9:0];
        end else if (e_ext >= 12'sd1) begin
            left = 1'b1;
            sh   = 6'(e_ext - 12'sd1);
            nexp = 10'd1;
        end else begin
            left = 1'b0;
            sh   = (r_amt > 12'sd50) ? 6'd50 : r_amt[5:0];
            nexp = 10'd1;
        end
    end

    logic [47:0]        s2_p_reg;
    logic               s2_left_reg, s2_zero_reg;
    logic [5:0]         s2_sh_reg;
    logic [9:0]         s2_exp_reg;
    fscrs_pkg::spec_t   s2_spec_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_p_reg    <= s1_p_reg;
            s2_left_reg <= left;
            s2_sh_reg   <= sh;
            s2_exp_reg  <= nexp;
            s2_zero_reg <= s1_zero_reg;
            s2_spec_reg <= s1_spec_reg;
        end
    end

    // stage 3: normalize or denormalize with sticky collection
    logic [47:0] nval;
    logic        nst;

    always_comb begin
        if (s2_left_reg) begin
            nval = s2_p_reg << s2_sh_reg;
            nst  = 1'b0;
        end else begin
            nval = s2_p_reg >> s2_sh_reg;
            nst  = ((nval << s2_sh_reg) != s2_p_reg);
        end
    end

    logic [47:0]        s3_n_reg;
    logic               s3_st_reg, s3_zero_reg;
    logic [9:0]         s3_exp_reg;
    fscrs_pkg::spec_t   s3_spec_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_n_reg    <= nval;
            s3_st_reg   <= nst;
            s3_exp_reg  <= s2_exp_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_spec_reg <= s2_spec_reg;
        end
    end

    // stage 4: round to nearest even and pack
    logic        sticky, rnd_up;
    logic [24:0] mant;
    logic [23:0] mfin;
    logic [9:0]  efin;
    logic [7:0]  efld;
    logic [31:0] prod_next;

    always_comb begin
        sticky = (|s3_n_reg[22:0]) | s3_st_reg;
        rnd_up = s3_n_reg[23] & (sticky | s3_n_reg[24]);
        mant   = {1'b0, s3_n_reg[47:24]} + {24'd0, rnd_up};
        if (mant[24]) begin
            mfin = mant[24:1];
            efin = s3_exp_reg + 10'd1;
        end else begin
            mfin = mant[23:0];
            efin = s3_exp_reg;
        end
        efld = mfin[23] ? efin[7:0] : 8'd0;
        if (s3_spec_reg.nan) begin
            prod_next = fscrs_pkg::QNAN;
        end else if (s3_spec_reg.inf) begin
            prod_next = {s3_spec_reg.sgn, fscrs_pkg::EXP_MAX, 23'd0};
        end else if (s3_zero_reg) begin
            prod_next = {s3_spec_reg.sgn, 31'd0};
        end else if (efin >= 10'd255) begin
            prod_next = {s3_spec_reg.sgn, fscrs_pkg::EXP_MAX, 23'd0};
        end else begin
            prod_next = {s3_spec_reg.sgn, efld, mfin[22:0]};
        end
    end

    logic [31:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

>>> design/float_sign_change_root_sweep.sv
// top level of the float sign-change root sweep pipeline
//
// Input channel (s_valid/s_ready/s_magnitude_code): one transaction per
// non-negative binary32 code z0. The block evaluates f(z) = (z - a)(z + b)
// on +z0, +z0+1, -z0, -(z0+1) and emits a root candidate for each pair whose
// product f0*f1 is <= 0: zero, one or two result transactions per input.
// Result channel (m_valid/m_ready/m_root_code/m_last): m_last marks the final
// root of an input; inputs that give no root produce no transaction.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0
// writes a, index 1 writes b; always ready; write only while idle.
// Path: the first root reaches m_valid through the input register, the
// 4-stage adders, two 4-stage multipliers in series, the result buffer
// and the output register.
// Throughput: one input per cycle while not stalled; an input with two roots
// holds the result buffer as the output register moves one root per cycle.
// Receiver stall: the whole pipeline freezes with its valid bits, nothing is
// dropped, and s_ready falls once the result buffer cannot drain.
// Reset clears all valid bits and loads a = 1.1 and b = 2.2.
module float_sign_change_root_sweep (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [30:0]           s_magnitude_code,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_root_code,
    output logic                  m_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  fscrs_pkg::cfg_idx_t   cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam int DEPTH = 13;

    logic en;

    // configuration registers
    logic [31:0] offset_a_reg, offset_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_a_reg <= fscrs_pkg::RESET_OFFSET_A;
            offset_b_reg <= fscrs_pkg::RESET_OFFSET_B;
        end else if (cfg_valid) begin
            case (cfg_index)
                fscrs_pkg::REG_OFFSET_A: offset_a_reg <= cfg_data;
                fscrs_pkg::REG_OFFSET_B: offset_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits and z0 travel down the pipeline together
    logic        vld_reg [0:DEPTH-1];
    logic [30:0] z_reg   [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < DEPTH; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg[0] <= s_magnitude_code;
            for (int i = 1; i < DEPTH; i++) z_reg[i] <= z_reg[i-1];
        end
    end

    // the four evaluation points: +z0, +z1, -z0, -z1
    logic [31:0]       z0_pos, z1_pos;
    logic [3:0][31:0]  z_pt, lo_val, hi_val, f_val;
    logic [31:0]       neg_a;

    assign z0_pos  = {1'b0, z_reg[0]};
    assign z1_pos  = z0_pos + 32'd1;
    assign z_pt[0] = z0_pos;
    assign z_pt[1] = z1_pos;
    assign z_pt[2] = z0_pos ^ fscrs_pkg::SIGN_MASK;
    assign z_pt[3] = z1_pos ^ fscrs_pkg::SIGN_MASK;
    assign neg_a   = offset_a_reg ^ fscrs_pkg::SIGN_MASK;

    for (genvar k = 0; k < 4; k++) begin : g_eval
        fscrs_add u_lo (
            .aclk (aclk),
            .en   (en),
            .op_a (z_pt[k]),
            .op_b (neg_a),
            .sum  (lo_val[k])
        );
        fscrs_add u_hi (
            .aclk (aclk),
            .en   (en),
            .op_a (z_pt[k]),
            .op_b (offset_b_reg),
            .sum  (hi_val[k])
        );
        fscrs_mul u_f (
            .aclk (aclk),
            .en   (en),
            .op_a (lo_val[k]),
            .op_b (hi_val[k]),
            .prod (f_val[k])
        );
    end

    // pair products, with f values delayed to meet them
    logic [31:0]      prod_pos, prod_neg;
    logic [3:0][31:0] f_dly_reg [0:3];

    fscrs_mul u_prod_pos (
        .aclk (aclk),
        .en   (en),
        .op_a (f_val[0]),
        .op_b (f_val[1]),
        .prod (prod_pos)
    );

    fscrs_mul u_prod_neg (
        .aclk (aclk),
        .en   (en),
        .op_a (f_val[2]),
        .op_b (f_val[3]),
        .prod (prod_neg)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            f_dly_reg[0] <= f_val;
            for (int i = 1; i < 4; i++) f_dly_reg[i] <= f_dly_reg[i-1];
        end
    end

    // bracket test and pick of the smaller |f|
    logic [31:0]      zd0, zd1;
    logic [3:0][31:0] fd;
    logic             hit_pos, hit_neg, le_pos, le_neg;
    logic [31:0]      pick_pos, pick_neg;

    always_comb begin
        fd  = f_dly_reg[3];
        zd0 = {1'b0, z_reg[DEPTH-1]};
        zd1 = zd0 + 32'd1;
        hit_pos = !((prod_pos[30:23] == fscrs_pkg::EXP_MAX) && (prod_pos[22:0] != 23'd0))
                  && (prod_pos[31] || (prod_pos[30:0] == 31'd0));
        hit_neg = !((prod_neg[30:23] == fscrs_pkg::EXP_MAX) && (prod_neg[22:0] != 23'd0))
                  && (prod_neg[31] || (prod_neg[30:0] == 31'd0));
        le_pos   = (fd[0][30:0] <= fd[1][30:0]);
        le_neg   = (fd[2][30:0] <= fd[3][30:0]);
        pick_pos = le_pos ? zd0 : zd1;
        pick_neg = le_neg ? (zd0 ^ fscrs_pkg::SIGN_MASK) : (zd1 ^ fscrs_pkg::SIGN_MASK);
    end

    // result buffer: holds one item's roots until the output register takes them
    logic        t_vld_reg, t_hit0_reg, t_hit1_reg;
    logic [31:0] t_pick0_reg, t_pick1_reg;
    logic        t_vld_next, t_hit0_next, t_hit1_next;
    logic [31:0] t_pick0_next, t_pick1_next;
    logic        o_free, o_load, t_done;

    logic        m_valid_reg, m_last_reg;
    logic [31:0] m_root_reg;
    logic        m_valid_next, m_last_next;
    logic [31:0] m_root_next;

    always_comb begin
        o_free = !m_valid_reg || m_ready;
        o_load = t_vld_reg && (t_hit0_reg || t_hit1_reg) && o_free;
        if (!t_vld_reg) begin
            t_done = 1'b0;
        end else if (!(t_hit0_reg || t_hit1_reg)) begin
            t_done = 1'b1;
        end else begin
            t_done = o_free && !(t_hit0_reg && t_hit1_reg);
        end
        en = !t_vld_reg || t_done;
    end

    always_comb begin
        t_vld_next   = t_vld_reg;
        t_hit0_next  = t_hit0_reg;
        t_hit1_next  = t_hit1_reg;
        t_pick0_next = t_pick0_reg;
        t_pick1_next = t_pick1_reg;
        if (en) begin
            t_vld_next   = vld_reg[DEPTH-1];
            t_hit0_next  = vld_reg[DEPTH-1] && hit_pos;
            t_hit1_next  = vld_reg[DEPTH-1] && hit_neg;
            t_pick0_next = pick_pos;
            t_pick1_next = pick_neg;
        end else if (o_load) begin
            // first of two roots leaves; the second stays
            t_hit0_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_root_next  = m_root_reg;
        m_last_next  = m_last_reg;
        if (o_load) begin
            m_valid_next = 1'b1;
            m_root_next  = t_hit0_reg ? t_pick0_reg : t_pick1_reg;
            m_last_next  = !(t_hit0_reg && t_hit1_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_vld_reg   <= 1'b0;
            t_hit0_reg  <= 1'b0;
            t_hit1_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            t_vld_reg   <= t_vld_next;
            t_hit0_reg  <= t_hit0_next;
            t_hit1_reg  <= t_hit1_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_pick0_reg <= t_pick0_next;
        t_pick1_reg <= t_pick1_next;
        m_root_reg  <= m_root_next;
        m_last_reg  <= m_last_next;
    end

    assign s_ready     = en;
    assign m_valid     = m_valid_reg;
    assign m_root_code = m_root_reg;
    assign m_last      = m_last_reg;

endmodule
